FILE: design/ber_tlv_header_parser_core_defines.svh
// Assertion macros shared by the parser modules.
`ifndef BER_TLV_HEADER_PARSER_CORE_DEFINES_SVH
`define BER_TLV_HEADER_PARSER_CORE_DEFINES_SVH

`ifndef SYNTH
`define BTP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BTP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BTP_ASSERT(lbl, clk, rst_n, prop, msg)
`define BTP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: design/btp_pkg.sv
package btp_pkg;

  localparam int MAX_DEPTH_DEF = 8;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [4:0] TAG_LONG_FORM  = 5'h1f;
  localparam int         CONS_BIT       = 5;
  localparam logic [2:0] LEN_LONG_MAX   = 3'd4;

  typedef enum logic [1:0] {
    EV_HEADER  = 2'd0,
    EV_CONTENT = 2'd1,
    EV_END     = 2'd2,
    EV_ERROR   = 2'd3
  } event_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_LEN_FORM = 2'd1,
    ERR_TOO_DEEP = 2'd2
  } err_code_t;

  typedef struct packed {
    event_kind_t kind;
    logic [15:0] tag;
    logic [31:0] len;
    logic        cons;
    logic [3:0]  depth;
    logic [7:0]  cbyte;
    err_code_t   err;
    logic        last;
  } result_t;

endpackage

FILE: design/btp_if.sv
interface btp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface btp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [15:0] tag_number;
  logic [31:0] content_length;
  logic        is_constructed;
  logic [3:0]  nest_depth;
  logic [7:0]  content_byte;
  logic [1:0]  error_code;
  logic        last_of_run;

  modport source (output valid, output event_kind, output tag_number, output content_length,
                  output is_constructed, output nest_depth, output content_byte,
                  output error_code, output last_of_run, input ready);
  modport sink   (input valid, input event_kind, input tag_number, input content_length,
                  input is_constructed, input nest_depth, input content_byte,
                  input error_code, input last_of_run, output ready);
endinterface

FILE: design/btp_front.sv
`include "ber_tlv_header_parser_core_defines.svh"

module btp_front import btp_pkg::*; #(
  parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  btp_in_if.sink  in_ch,
  input  logic    q_full,
  output logic    q_wr,
  output result_t q_data
);

  localparam int LVL_W = $clog2(MAX_DEPTH + 1);
  localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  typedef enum logic [2:0] {
    PH_TAG1,
    PH_TAG2,
    PH_LEN,
    PH_LENX,
    PH_BODY
  } phase_t;

  logic [31:0]      pos_r, pos_nxt;
  phase_t           phase_r, phase_nxt;
  logic [15:0]      tag_r, tag_nxt;
  logic [31:0]      len_r, len_nxt;
  logic [2:0]       lbl_r, lbl_nxt;
  logic [31:0]      cleft_r, cleft_nxt;
  logic             cons_r, cons_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;
  logic             closing_r, closing_nxt;
  logic [31:0]      stack_r [MAX_DEPTH];

  logic             acc;
  logic [7:0]       b;
  logic [31:0]      p0, pos_n, fin_len, push_end, top;
  logic [LVL_W-1:0] lvl0, lvl1, lvl1_dec, lvl_dec2;
  phase_t           ph0, ph_n;
  logic             prim_v, fin, push, closes, more;
  result_t          prim;
  logic [IDX_W-1:0] idx_top, idx_next;

  assign in_ch.ready = !closing_r && !q_full;
  assign acc         = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;

  always_comb begin
    p0        = in_ch.frame_start ? 32'd0 : pos_r;
    lvl0      = in_ch.frame_start ? '0 : level_r;
    ph0       = in_ch.frame_start ? PH_TAG1 : phase_r;
    pos_n     = p0 + 32'd1;
    ph_n      = ph0;
    tag_nxt   = tag_r;
    len_nxt   = len_r;
    lbl_nxt   = lbl_r;
    cleft_nxt = cleft_r;
    cons_nxt  = cons_r;
    fin       = 1'b0;
    fin_len   = 32'd0;
    push      = 1'b0;
    prim_v    = 1'b0;
    prim      = '0;
    case (ph0)
      PH_TAG2: begin
        tag_nxt = {tag_r[7:0], b};
        ph_n    = PH_LEN;
      end
      PH_LEN: begin
        len_nxt = 32'd0;
        if (!b[7]) begin
          len_nxt = {24'd0, b};
          fin     = 1'b1;
          fin_len = {24'd0, b};
        end else if (b[6:3] == 4'd0 && b[2:0] != 3'd0 && b[2:0] <= LEN_LONG_MAX) begin
          lbl_nxt = b[2:0];
          ph_n    = PH_LENX;
        end else begin
          prim_v      = 1'b1;
          prim.kind   = EV_ERROR;
          prim.tag    = tag_r;
          prim.cons   = cons_r;
          prim.err    = ERR_LEN_FORM;
          ph_n        = PH_TAG1;
        end
      end
      PH_LENX: begin
        len_nxt = {len_r[23:0], b};
        lbl_nxt = lbl_r - 3'd1;
        if (lbl_nxt == 3'd0) begin
          fin     = 1'b1;
          fin_len = len_nxt;
        end
      end
      PH_BODY: begin
        prim_v     = 1'b1;
        prim.kind  = EV_CONTENT;
        prim.tag   = tag_r;
        prim.len   = len_r;
        prim.cbyte = b;
        cleft_nxt  = cleft_r - 32'd1;
        if (cleft_nxt == 32'd0) begin
          ph_n = PH_TAG1;
        end
      end
      default: begin
        tag_nxt  = {8'd0, b};
        cons_nxt = b[CONS_BIT];
        ph_n     = (b[4:0] == TAG_LONG_FORM) ? PH_TAG2 : PH_LEN;
      end
    endcase

    if (fin) begin
      prim_v    = 1'b1;
      prim.tag  = tag_r;
      prim.len  = fin_len;
      prim.cons = cons_r;
      if (cons_r) begin
        ph_n = PH_TAG1;
        if (lvl0 >= LVL_W'(MAX_DEPTH)) begin
          prim.kind = EV_ERROR;
          prim.err  = ERR_TOO_DEEP;
        end else begin
          prim.kind = EV_HEADER;
          push      = 1'b1;
        end
      end else begin
        prim.kind = EV_HEADER;
        if (fin_len == 32'd0) begin
          ph_n = PH_TAG1;
        end else begin
          cleft_nxt = fin_len;
          ph_n      = PH_BODY;
        end
      end
    end

    lvl1       = lvl0 + LVL_W'(push);
    lvl1_dec   = lvl1 - LVL_W'(1);
    idx_top    = lvl1_dec[IDX_W-1:0];
    push_end   = pos_n + fin_len;
    top        = push ? push_end : stack_r[idx_top];
    closes     = (ph_n == PH_TAG1) && (lvl1 != '0) && (pos_n >= top);
    prim.depth = 4'(lvl1);
    prim.last  = !closes;
  end

  // close sequencer: one level popped per cycle while the queue is not full
  always_comb begin
    lvl_dec2 = level_r - LVL_W'(2);
    idx_next = lvl_dec2[IDX_W-1:0];
    more     = (level_r > LVL_W'(1)) && (pos_r >= stack_r[idx_next]);
  end

  always_comb begin
    pos_nxt     = pos_r;
    phase_nxt   = phase_r;
    level_nxt   = level_r;
    closing_nxt = closing_r;
    q_wr        = 1'b0;
    q_data      = prim;
    if (acc) begin
      pos_nxt     = pos_n;
      phase_nxt   = ph_n;
      level_nxt   = lvl1;
      closing_nxt = closes;
      q_wr        = prim_v;
    end else if (closing_r && !q_full) begin
      level_nxt    = level_r - LVL_W'(1);
      closing_nxt  = more;
      q_wr         = 1'b1;
      q_data       = '0;
      q_data.kind  = EV_END;
      q_data.cons  = 1'b1;
      q_data.depth = 4'(level_nxt);
      q_data.err   = ERR_NONE;
      q_data.last  = !more;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= 32'd0;
      phase_r   <= PH_TAG1;
      tag_r     <= 16'd0;
      len_r     <= 32'd0;
      lbl_r     <= 3'd0;
      cleft_r   <= 32'd0;
      cons_r    <= 1'b0;
      level_r   <= '0;
      closing_r <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      phase_r   <= phase_nxt;
      level_r   <= level_nxt;
      closing_r <= closing_nxt;
      if (acc) begin
        tag_r   <= tag_nxt;
        len_r   <= len_nxt;
        lbl_r   <= lbl_nxt;
        cleft_r <= cleft_nxt;
        cons_r  <= cons_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && push) begin
      stack_r[lvl0[IDX_W-1:0]] <= push_end;
    end
  end

  `BTP_ASSERT(a_level_bound, clk, rst_n, level_r <= LVL_W'(MAX_DEPTH), "nesting level overflow")
  `BTP_ASSERT(a_close_end_only, clk, rst_n, (closing_r && q_wr) |-> (q_data.kind == EV_END), "non-end transfer while closing")
  `BTP_ASSERT(a_close_needs_tag1, clk, rst_n, (acc && ph_n != PH_TAG1) |=> !closing_r, "closing inside a header or body")
  `BTP_ASSERT(a_close_nonempty, clk, rst_n, closing_r |-> (level_r != '0), "closing with no open level")

endmodule

FILE: design/btp_queue.sv
`include "ber_tlv_header_parser_core_defines.svh"

module btp_queue import btp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr,
  input  result_t wr_data,
  output logic    full,
  input  logic    rd,
  output result_t rd_data,
  output logic    empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  result_t          mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (rd) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_r + CNT_W'(wr) - CNT_W'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  `BTP_ASSERT(a_no_overflow, clk, rst_n, full |-> !wr, "write into full queue")
  `BTP_ASSERT(a_no_underflow, clk, rst_n, empty |-> !rd, "read from empty queue")

endmodule

FILE: design/btp_back.sv
module btp_back import btp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  result_t   q_data,
  output logic      q_rd,
  btp_out_if.source out_ch
);

  logic    out_valid_r, out_valid_nxt;
  result_t out_data_r;

  assign q_rd          = !q_empty && (!out_valid_r || out_ch.ready);
  assign out_valid_nxt = q_rd || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (q_rd) begin
      out_data_r <= q_data;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.event_kind     = out_data_r.kind;
  assign out_ch.tag_number     = out_data_r.tag;
  assign out_ch.content_length = out_data_r.len;
  assign out_ch.is_constructed = out_data_r.cons;
  assign out_ch.nest_depth     = out_data_r.depth;
  assign out_ch.content_byte   = out_data_r.cbyte;
  assign out_ch.error_code     = out_data_r.err;
  assign out_ch.last_of_run    = out_data_r.last;

endmodule

FILE: design/ber_tlv_header_parser_core.sv
// BER TLV header parser. Bytes enter on in_ch, one per cycle while ready; each byte yields
// zero or more header, content, end or error results on out_ch, the final one of a byte marked
// by last_of_run. The close sequencer pops one end-position stack entry per cycle while the
// queue has room, one per nested level a byte closes, and holds off new bytes meanwhile.
// Results pass through a four-entry queue and an output register, so bytes are taken while
// results wait, until the queue fills. The end-position stack needs no clearing after reset.
module ber_tlv_header_parser_core import btp_pkg::*; #(
  parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  btp_in_if.sink    in_ch,
  btp_out_if.source out_ch
);

  logic    q_wr, q_full, q_rd, q_empty;
  result_t q_wr_data, q_rd_data;

  btp_front #(.MAX_DEPTH(MAX_DEPTH)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_wr   (q_wr),
    .q_data (q_wr_data)
  );

  btp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd      (q_rd),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  btp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (q_rd_data),
    .q_rd    (q_rd),
    .out_ch  (out_ch)
  );

endmodule

FILE: dv/ber_tlv_header_parser_core_test.sv
`timescale 1ns / 1ps

module ber_tlv_header_parser_core_test;
  import btp_pkg::*;

  localparam int DEPTH = MAX_DEPTH_DEF;
  localparam int MAX_LVL = DEPTH + 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int BYTES_PER_PHASE = 72;
  localparam int NUM_PHASES = 6;

  typedef enum logic [2:0] {
    PH_FIRST_TAG,
    PH_SECOND_TAG,
    PH_LENGTH,
    PH_LENGTH_MORE,
    PH_CONTENT
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] b;
    logic       fs;
  } stream_byte_t;

  typedef struct {
    int         lvl;
    logic       cons;
    logic [7:0] t1;
    logic [7:0] t2;
    int         plen;
  } tlv_node_t;

  logic clk;
  logic rst_n;

  btp_in_if  in_ch ();
  btp_out_if out_ch ();

  ber_tlv_header_parser_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  stream_byte_t pending_bytes[$];
  result_t      predicted_events[$];
  result_t      want_event;
  logic         byte_taken = 1'b0;
  logic         resync = 1'b1;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           mismatches = 0;
  int           events_checked = 0;
  int           cycle_count = 0;

  parse_phase_t parse_phase = PH_FIRST_TAG;
  logic [31:0]  stream_pos = '0;
  logic [15:0]  tag_acc = '0;
  logic [31:0]  len_acc = '0;
  logic [2:0]   len_bytes_left = '0;
  logic [31:0]  content_left = '0;
  logic [31:0]  end_pos [DEPTH];
  int           open_levels = 0;
  logic         cons_flag = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void push_event(event_kind_t kind, logic [15:0] tag, logic [31:0] len,
                                     logic cons, logic [7:0] cbyte, err_code_t err);
    result_t r;
    r.kind = kind;
    r.tag = tag;
    r.len = len;
    r.cons = cons;
    r.depth = 4'(open_levels);
    r.cbyte = cbyte;
    r.err = err;
    r.last = 1'b0;
    predicted_events = {predicted_events, r};
  endfunction

  function automatic void finish_header();
    if (cons_flag) begin
      if (open_levels >= DEPTH) begin
        push_event(EV_ERROR, tag_acc, len_acc, 1'b1, 8'd0, ERR_TOO_DEEP);
      end else begin
        end_pos[open_levels] = stream_pos + len_acc;
        open_levels++;
        push_event(EV_HEADER, tag_acc, len_acc, 1'b1, 8'd0, ERR_NONE);
      end
      parse_phase = PH_FIRST_TAG;
    end else begin
      push_event(EV_HEADER, tag_acc, len_acc, 1'b0, 8'd0, ERR_NONE);
      if (len_acc == 0) begin
        parse_phase = PH_FIRST_TAG;
      end else begin
        content_left = len_acc;
        parse_phase = PH_CONTENT;
      end
    end
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic fs);
    int first;
    first = predicted_events.size();
    if (fs) begin
      stream_pos = '0;
      open_levels = 0;
      parse_phase = PH_FIRST_TAG;
    end
    stream_pos = stream_pos + 1;
    case (parse_phase)
      PH_SECOND_TAG: begin
        tag_acc = {tag_acc[7:0], b};
        parse_phase = PH_LENGTH;
      end
      PH_LENGTH: begin
        len_acc = '0;
        if (b < 8'h80) begin
          len_acc = {24'd0, b};
          finish_header();
        end else if (b[6:0] >= 7'd1 && b[6:0] <= 7'(LEN_LONG_MAX)) begin
          len_bytes_left = b[2:0];
          parse_phase = PH_LENGTH_MORE;
        end else begin
          push_event(EV_ERROR, tag_acc, 32'd0, cons_flag, 8'd0, ERR_LEN_FORM);
          parse_phase = PH_FIRST_TAG;
        end
      end
      PH_LENGTH_MORE: begin
        len_acc = {len_acc[23:0], b};
        len_bytes_left = len_bytes_left - 3'd1;
        if (len_bytes_left == 3'd0) finish_header();
      end
      PH_CONTENT: begin
        push_event(EV_CONTENT, tag_acc, len_acc, 1'b0, b, ERR_NONE);
        content_left = content_left - 1;
        if (content_left == 0) parse_phase = PH_FIRST_TAG;
      end
      default: begin
        tag_acc = {8'd0, b};
        cons_flag = b[CONS_BIT];
        parse_phase = (b[4:0] == TAG_LONG_FORM) ? PH_SECOND_TAG : PH_LENGTH;
      end
    endcase
    if (parse_phase == PH_FIRST_TAG) begin
      while (open_levels > 0 && stream_pos >= end_pos[open_levels - 1]) begin
        open_levels--;
        push_event(EV_END, 16'd0, 32'd0, 1'b1, 8'd0, ERR_NONE);
      end
    end
    if (predicted_events.size() > first) predicted_events[predicted_events.size() - 1].last = 1'b1;
  endfunction

  function automatic void push_byte(logic [7:0] b, logic fs);
    stream_byte_t sb;
    sb.b = b;
    sb.fs = fs;
    pending_bytes = {pending_bytes, sb};
  endfunction

  // Mostly well-formed frames with random content; the rest is noise, cut frames and bad lengths.
  function automatic void queue_random_stream(int n_bytes);
    tlv_node_t    nodes[$];
    tlv_node_t    nd;
    logic [7:0]   acc [MAX_LVL + 1][$];
    logic [7:0]   enc[$];
    logic [7:0]   frame[$];
    logic [7:0]   tag_b;
    int           left [MAX_LVL + 1];
    int           lvl;
    int           added;
    int           pick;
    int           width;
    int           min_width;
    int           cut;
    logic [31:0]  hdr_len;
    logic         broken;
    added = 0;
    while (added < n_bytes) begin
      frame.delete();
      broken = 1'b0;
      pick = $urandom_range(99);
      if (pick < 80) begin
        nodes.delete();
        lvl = 0;
        left[0] = 1;
        while (lvl >= 0) begin
          if (left[lvl] == 0) begin
            lvl--;
          end else begin
            left[lvl]--;
            nd.lvl = lvl;
            nd.cons = (lvl < MAX_LVL - 1) && ($urandom_range(99) < ((lvl < 3) ? 50 : 20));
            nd.t1 = 8'($urandom);
            nd.t2 = 8'($urandom);
            nd.t1[CONS_BIT] = nd.cons;
            if ($urandom_range(4) == 0) nd.t1[4:0] = TAG_LONG_FORM;
            else if (nd.t1[4:0] == TAG_LONG_FORM) nd.t1[0] = 1'b0;
            nd.plen = ($urandom_range(19) == 0) ? $urandom_range(130) : $urandom_range(5);
            nodes = {nodes, nd};
            if (nd.cons) begin
              lvl++;
              left[lvl] = $urandom_range(3);
            end
          end
        end
        for (int i = nodes.size() - 1; i >= 0; i--) begin
          nd = nodes[i];
          enc.delete();
          enc = {enc, nd.t1};
          if (nd.t1[4:0] == TAG_LONG_FORM) enc = {enc, nd.t2};
          if (nd.cons) begin
            hdr_len = acc[nd.lvl + 1].size();
            if ($urandom_range(9) == 0) hdr_len = $urandom_range(hdr_len + 3, 0);
          end else begin
            hdr_len = nd.plen;
          end
          if (hdr_len < 128 && $urandom_range(3) != 0) begin
            enc = {enc, hdr_len[7:0]};
          end else begin
            min_width = (hdr_len > 32'hff_ffff) ? 4 : (hdr_len > 32'hffff) ? 3 :
                        (hdr_len > 32'hff) ? 2 : 1;
            width = $urandom_range(4, min_width);
            enc = {enc, 8'h80 | 8'(width)};
            for (int j = width - 1; j >= 0; j--) enc = {enc, 8'(hdr_len >> (8 * j))};
          end
          if (nd.cons) begin
            enc = {enc, acc[nd.lvl + 1]};
            acc[nd.lvl + 1].delete();
          end else begin
            repeat (nd.plen) enc = {enc, 8'($urandom)};
          end
          acc[nd.lvl] = {enc, acc[nd.lvl]};
        end
        frame = acc[0];
        acc[0].delete();
        if ($urandom_range(9) == 0 && frame.size() > 1) begin
          cut = $urandom_range(frame.size() - 1, 1);
          frame = frame[0:cut - 1];
          broken = 1'b1;
        end
      end else if (pick < 92) begin
        repeat ($urandom_range(6, 1)) frame = {frame, 8'($urandom)};
        broken = 1'b1;
      end else begin
        tag_b = 8'($urandom);
        if (tag_b[4:0] == TAG_LONG_FORM) tag_b[0] = 1'b0;
        frame = {frame, tag_b};
        frame = {frame, ($urandom_range(1) == 0) ? 8'h80 : 8'($urandom_range(255, 133))};
      end
      for (int i = 0; i < frame.size(); i++)
        push_byte(frame[i], (i == 0) && (resync || $urandom_range(99) < 25));
      added += frame.size();
      resync = broken;
    end
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                events_checked, name, got, want));
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || byte_taken) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= pending_bytes[0].b;
        in_ch.frame_start <= pending_bytes[0].fs;
        void'(pending_bytes.pop_front());
      end else begin
        in_ch.valid <= 1'b0;
        in_ch.data_byte <= 8'($urandom);
        in_ch.frame_start <= 1'($urandom);
      end
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    byte_taken = rst_n && in_ch.valid && in_ch.ready;
    if (byte_taken) parse_byte(in_ch.data_byte, in_ch.frame_start);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (predicted_events.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", events_checked));
      end else begin
        want_event = predicted_events.pop_front();
        check_field("event_kind", out_ch.event_kind, want_event.kind);
        check_field("tag_number", out_ch.tag_number, want_event.tag);
        check_field("content_length", out_ch.content_length, want_event.len);
        check_field("is_constructed", out_ch.is_constructed, want_event.cons);
        check_field("nest_depth", out_ch.nest_depth, want_event.depth);
        check_field("content_byte", out_ch.content_byte, want_event.cbyte);
        check_field("error_code", out_ch.error_code, want_event.err);
        check_field("last_of_run", out_ch.last_of_run, want_event.last);
      end
      events_checked++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'd0;
    in_ch.frame_start = 1'b0;
    out_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    for (int p = 0; p < NUM_PHASES; p++) begin
      send_idle_pct = (p == 2) ? 79 : (p == 4) ? 35 : 0;
      recv_stall_pct = (p == 3) ? 79 : (p == 4) ? 35 : 0;
      if (p == 0) begin
        // nine nested constructed headers: the last one is too deep and all eight levels close
        for (int k = 0; k <= DEPTH; k++) begin
          push_byte(8'h20 + 8'(k), k == 0);
          push_byte(8'(2 * DEPTH - 2 * k), 1'b0);
        end
        push_byte(8'h3f, 1'b1);
        push_byte(8'hff, 1'b0);
        push_byte(8'h80, 1'b0);
        // constructed item whose end position wraps and closes at once
        push_byte(8'h20, 1'b1);
        push_byte(8'h84, 1'b0);
        repeat (4) push_byte(8'hff, 1'b0);
        push_byte(8'hc1, 1'b0);
        push_byte(8'hff, 1'b0);
      end else begin
        queue_random_stream(BYTES_PER_PHASE);
      end
      while (pending_bytes.size() != 0 || in_ch.valid) @(posedge clk);
      if (p == 3) begin
        while (predicted_events.size() != 0) @(posedge clk);
      end
    end
    while (predicted_events.size() != 0) @(posedge clk);
    repeat (2 * MAX_LVL + 20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
